@@ hw/rtl/tcw_pkg.sv @@
// Shared types, constants and helpers for the text console writer.
// Depends on nothing; every other file of the block imports it.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int COLX_W     = COL_W + 1;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ROWX_W     = ROW_W + 1;
  localparam int TAB_STOP   = 4;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int POS_W   = 11;
  localparam int RES_W   = CELL_W + POS_W + 1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - RES_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the input kind field
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, BLANK_CHAR};

  typedef enum logic [2:0] {
    K_PRINT,
    K_BS,
    K_LF,
    K_CR,
    K_TAB,
    K_NOP,
    K_READ,
    K_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [CHAR_W-1:0]      char_code;
    logic [INDEX_W-1:0]     cell_index;
    logic                   index_ok;
  } cmd_t;

  typedef struct packed {
    logic                   scrolled;
    logic [POS_W-1:0]       cursor_pos;
    logic [CELL_W-1:0]      cell_data;
  } res_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } back_state_e;

  // Linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  // Next tab stop, one bit wider than a column so that it may pass the edge
  function automatic logic [COLX_W-1:0] next_tab(input logic [COL_W-1:0] col);
    logic [COLX_W-1:0] sum;
    sum = {1'b0, col} + COLX_W'(TAB_STOP);
    return sum & ~COLX_W'(TAB_STOP - 1);
  endfunction

endpackage

@@ hw/rtl/tcw_front.sv @@
// Front end of the text console writer: classifies input transfers and queues them.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FUNC_W-1:0]  in_func_i,
  input  logic [CHAR_W-1:0]  in_char_i,
  input  logic [INDEX_W-1:0] in_index_i,
  input  logic               init_busy_i,
  output logic               head_valid_o,
  output cmd_t               head_o,
  input  logic               pop_i
);

  cmd_t              cmd;
  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;

  always_comb begin
    cmd.char_code  = in_char_i;
    cmd.cell_index = in_index_i;
    cmd.index_ok   = 32'(in_index_i) < 32'(CELL_COUNT);
    unique case (in_func_i)
      FUNC_PUT: begin
        unique case (in_char_i)
          CH_BS:   cmd.kind = K_BS;
          CH_TAB:  cmd.kind = K_TAB;
          CH_LF:   cmd.kind = K_LF;
          CH_CR:   cmd.kind = K_CR;
          default: begin
            // printable range runs from blank up to 0x7F
            cmd.kind = (in_char_i >= BLANK_CHAR && !in_char_i[CHAR_W-1]) ? K_PRINT : K_NOP;
          end
        endcase
      end
      FUNC_READ:  cmd.kind = K_READ;
      FUNC_CLEAR: cmd.kind = K_CLEAR;
      default:    cmd.kind = K_NOP;
    endcase
  end

  assign in_ready_o   = (count_q != QCNT_W'(QUEUE_DEPTH)) && !init_busy_i;
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = count_q != '0;
  assign head_o       = queue_q[rd_ptr_q];
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

@@ hw/rtl/tcw_back.sv @@
// Back end of the text console writer: cursor, screen memory, row walks, result register.
// Depends on tcw_pkg.
module tcw_back import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  input  logic              head_valid_i,
  input  cmd_t              head_i,
  output logic              pop_o,
  output logic              init_busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_o
);

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic              idx_ok_q, idx_ok_d;
  logic              res_scr_q, res_scr_d;
  logic [ATTR_W-1:0] attr_q;
  logic              out_valid_q;
  res_t              out_q, res_d;
  logic              load_out;
  logic              out_free;
  logic [COLX_W-1:0] col_x;
  logic [ROWX_W-1:0] row_x;
  logic              scroll;

  logic [CELL_W-1:0] screen_q [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  assign out_free    = !out_valid_q || out_ready_i;
  assign init_busy_o = state_q == ST_INIT;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    idx_ok_d    = idx_ok_q;
    res_scr_d   = res_scr_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    load_out    = 1'b0;
    res_d       = '0;
    pop_o       = 1'b0;
    col_x       = {1'b0, col_q};
    row_x       = {1'b0, row_q};
    scroll      = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[ADDR_W-1:0];
        mem_wdata = RESET_CELL;
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (head_valid_i && out_free) begin
          pop_o = 1'b1;
          unique case (head_i.kind)
            K_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(row_q, col_q);
              mem_wdata = {attr_q, head_i.char_code};
              col_x     = col_x + 1'b1;
            end
            K_BS: begin
              if (col_q != '0) begin
                col_x = col_x - 1'b1;
              end
            end
            K_LF: begin
              col_x = '0;
              row_x = row_x + 1'b1;
            end
            K_CR:  col_x = '0;
            K_TAB: col_x = next_tab(col_q);
            K_NOP: ;
            K_READ: begin
              mem_re    = head_i.index_ok;
              mem_raddr = ADDR_W'(head_i.cell_index);
              idx_ok_d  = head_i.index_ok;
              state_d   = ST_READ;
            end
            K_CLEAR: begin
              cnt_d     = '0;
              res_scr_d = 1'b0;
              state_d   = ST_FILL;
            end
          endcase
          // wrap at the right edge, then scroll at the bottom
          if (col_x >= COLX_W'(COLUMNS)) begin
            col_x = '0;
            row_x = row_x + 1'b1;
          end
          scroll = row_x >= ROWX_W'(ROWS);
          if (scroll) begin
            row_x = ROWX_W'(ROWS - 1);
          end
          col_d = col_x[COL_W-1:0];
          row_d = row_x[ROW_W-1:0];
          if (scroll) begin
            state_d   = ST_SCROLL;
            cnt_d     = CNT_W'(COLUMNS);
            res_scr_d = 1'b1;
          end else if (head_i.kind != K_READ && head_i.kind != K_CLEAR) begin
            load_out = 1'b1;
          end
        end
      end

      ST_READ: begin
        load_out        = 1'b1;
        res_d.cell_data = idx_ok_q ? rd_data_q : '0;
        state_d         = ST_IDLE;
      end

      ST_SCROLL: begin
        // read one row ahead, write the cell read in the previous cycle one row up
        if (cnt_q != CNT_W'(CELL_COUNT)) begin
          mem_re      = 1'b1;
          mem_raddr   = cnt_q[ADDR_W-1:0];
          pend_d      = 1'b1;
          pend_addr_d = ADDR_W'(cnt_q - CNT_W'(COLUMNS));
          cnt_d       = cnt_q + 1'b1;
        end else begin
          state_d = ST_FILL;
          cnt_d   = CNT_W'(CELL_COUNT - COLUMNS);
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_q;
          mem_wdata = rd_data_q;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[ADDR_W-1:0];
        mem_wdata = {attr_q, BLANK_CHAR};
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          load_out       = 1'b1;
          res_d.scrolled = res_scr_q;
          state_d        = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      default: state_d = ST_INIT;
    endcase

    res_d.cursor_pos = POS_W'(cell_addr(row_d, col_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= 1'b0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    idx_ok_q    <= idx_ok_d;
    res_scr_q   <= res_scr_d;
    if (load_out) begin
      out_q <= res_d;
    end
  end

  // Screen memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= screen_q[mem_raddr];
    end
  end

endmodule

@@ hw/rtl/text_console_writer_core.sv @@
// Top level of the text console writer: stream ports, front end queue and back end.
// Depends on tcw_pkg, tcw_front and tcw_back.
//
// Text console over an 80x25 grid of 16-bit cells (attribute in the high byte,
// character in the low byte). Each input transfer carries an operation in tuser:
// put a character (control bytes backspace, tab, newline and carriage return are
// interpreted, 0x20..0x7F is written with the current attribute, anything else
// is dropped), read a cell, or clear the screen. Every operation gives exactly
// one output transfer with the cell read (0 for other operations), the linear
// cursor position and a flag that is set when the screen scrolled up one row.
// The front end classifies and holds up to two operations, so input keeps
// flowing while the back end works or the output stalls. Timing is set by the
// screen memory (one write and one read per cycle): characters and cursor
// moves are done in the back end's idle state, a cell read waits for the
// registered memory read, a clear blanks all 2000 cells, and a put that
// scrolls moves 1920 cells up one row, then writes 80 blanks. After reset the
// block blanks the whole screen in one pass with s_axis_tready low; attribute
// writes are taken at any time but must only be made while the block is idle.
module text_console_writer_core import tcw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input operations
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // char_code[7:0], cell_index[18:8]
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // func[1:0]
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // cell_data[15:0], cursor_pos[26:16],
                                                // scrolled[27]
  // attribute register
  input  logic                  cfg_we_i,
  input  logic [ATTR_W-1:0]     cfg_wdata_i
);

  cmd_t head;
  logic head_valid;
  logic pop;
  logic init_busy;
  res_t res;

  tcw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_func_i    (s_axis_tuser),
    .in_char_i    (s_axis_tdata[CHAR_W-1:0]),
    .in_index_i   (s_axis_tdata[CHAR_W +: INDEX_W]),
    .init_busy_i  (init_busy),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  tcw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  // pad the result up to whole bytes
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res};

endmodule

@@ hw/rtl/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_core.
module tcw_checker import tcw_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [POS_W-1:0] pos;
  logic             scr;

  assign pos = m_axis_tdata[CELL_W +: POS_W];
  assign scr = m_axis_tdata[CELL_W + POS_W];

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result transfer changed");

  // padding stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:RES_W] == '0)
    else $error("result padding not zero");

  // cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(pos) < 32'(CELL_COUNT))
    else $error("cursor position beyond the screen");

  // after a scroll the cursor sits on the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && scr |-> 32'(pos) >= 32'((ROWS - 1) * COLUMNS))
    else $error("scroll left cursor above the bottom row");

  // input is not ready when reset is released, as the screen blanking starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input ready during the reset blanking pass");

endmodule

bind text_console_writer_core tcw_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
